### hw/rtl/ttlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlb_pkg
// Shared types, character codes and helpers for the terminal text line buffer.
// ----------------------------------------------------------------------------
package ttlb_pkg;

   localparam int SCREEN_LINES_DEF = 6;
   localparam int LINE_COLUMNS_DEF = 21;

   // request operation codes
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
      logic [2:0] read_row;
      logic [4:0] read_col;
   } req_type;

   typedef struct packed {
      logic       log_valid;
      logic [7:0] log_byte;
      logic       in_escape;
      logic       line_advanced;
      logic       scrolled;
      logic [2:0] cursor_row;
      logic [4:0] cursor_col;
      logic [7:0] cell_char;
      logic [4:0] row_length;
   } rsp_type;

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_break(input logic [7:0] b);
      return (b == CH_LF) || (b == CH_CR);
   endfunction

   function automatic logic is_printable(input logic [7:0] b);
      return (b >= CH_SPACE) && (b <= CH_TILDE);
   endfunction

endpackage

### hw/rtl/terminal_text_line_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_text_line_buffer
// Escape-filtering byte receiver with a small scrolling text screen.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while req_stall is low; its response
// passes the RAM stage (registered RAM read) and then the output register.
// A two-deep response path (RAM stage plus output register) lets a new request
// in while a finished response waits. Cursor, escape state and row lengths sit
// in flip-flops and are updated in the accept cycle; the characters live in a
// SCREEN_LINES*LINE_COLUMNS byte RAM written once per stored byte. The RAM is
// not cleared after reset: a cell is only read below its row length, so every
// cell read has been written. The block is ready right after reset.
// ----------------------------------------------------------------------------
module terminal_text_line_buffer import ttlb_pkg::*; #(
   parameter int SCREEN_LINES = SCREEN_LINES_DEF,
   parameter int LINE_COLUMNS = LINE_COLUMNS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int ROW_W  = $clog2(SCREEN_LINES);
   localparam int LEN_W  = $clog2(LINE_COLUMNS + 1);
   localparam int DEPTH  = SCREEN_LINES * LINE_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_LINES - 1);
   localparam logic [LEN_W-1:0] COLS_LEN = LEN_W'(LINE_COLUMNS);

   // screen state
   logic [ROW_W-1:0] top_ff, top_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [ROW_W-1:0] cur_phys_ff, cur_phys_in;
   logic [LEN_W-1:0] cur_len_ff, cur_len_in;
   logic             esc_ff, esc_in;
   logic [7:0]       prev_ff, prev_in;
   logic [LEN_W-1:0] row_len_ff [SCREEN_LINES];

   // response path
   logic    s1_valid_ff, s1_valid_in;
   rsp_type s1_rsp_ff, s1_rsp_in;
   logic    s1_cell_en_ff, s1_cell_en_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic s1_move, accept, is_rx, is_rd;
   logic [7:0] rx_b;
   logic brk, prev_brk, fwd, advanced, scrolled, row_wr_en, need;

   logic [ROW_W-1:0]  rd_row, rd_phys;
   logic [ROW_W:0]    rd_sum;
   logic              rd_row_ok, rd_col_ok;
   logic [LEN_W-1:0]  rd_len;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_rdata;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;
   assign is_rx     = accept && (req_payload.operation == OP_RECEIVE);
   assign is_rd     = accept && (req_payload.operation == OP_READ);
   assign rx_b      = req_payload.rx_byte;
   assign brk       = is_break(rx_b);
   assign prev_brk  = is_break(prev_ff);

   // read lookup: screen row -> physical row
   always_comb begin
      rd_row    = ROW_W'(req_payload.read_row);
      rd_row_ok = 32'(req_payload.read_row) < 32'(SCREEN_LINES);
      rd_sum    = {1'b0, top_ff} + {1'b0, rd_row};
      if (rd_sum >= (ROW_W+1)'(SCREEN_LINES)) begin
         rd_sum = rd_sum - (ROW_W+1)'(SCREEN_LINES);
      end
      rd_phys   = rd_sum[ROW_W-1:0];
      rd_len    = rd_row_ok ? row_len_ff[rd_phys] : '0;
      rd_col_ok = 32'(req_payload.read_col) < 32'(rd_len);
      ram_re    = is_rd && rd_row_ok && rd_col_ok;
      ram_raddr = ADDR_W'(32'(rd_phys) * LINE_COLUMNS) + ADDR_W'(req_payload.read_col);
   end

   // receive path: filter, line advance, scroll, store
   always_comb begin
      top_in      = top_ff;
      cur_row_in  = cur_row_ff;
      cur_phys_in = cur_phys_ff;
      cur_len_in  = cur_len_ff;
      esc_in      = esc_ff;
      prev_in     = prev_ff;
      fwd         = 1'b0;
      need        = 1'b0;
      advanced    = 1'b0;
      scrolled    = 1'b0;
      row_wr_en   = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      if (is_rx) begin
         prev_in = rx_b;
         priority if (esc_ff) begin
            if (is_letter(rx_b)) begin
               esc_in = 1'b0;
            end
         end else if ((rx_b == CH_LBRACKET) && (prev_ff == CH_ESC)) begin
            esc_in = 1'b1;
         end else if (is_printable(rx_b) || brk) begin
            fwd       = 1'b1;
            row_wr_en = 1'b1;
            need      = (cur_len_ff >= COLS_LEN) || (brk && !prev_brk);
            if (need) begin
               advanced   = 1'b1;
               cur_len_in = '0;
               if (cur_row_ff != ROW_LAST) begin
                  // rows below the cursor are always empty
                  cur_row_in  = cur_row_ff + 1'b1;
                  cur_phys_in = (cur_phys_ff == ROW_LAST) ? '0 : cur_phys_ff + 1'b1;
               end else begin
                  // old top row becomes the new, cleared bottom row
                  scrolled    = 1'b1;
                  top_in      = (top_ff == ROW_LAST) ? '0 : top_ff + 1'b1;
                  cur_phys_in = top_ff;
               end
            end
            if (!brk && (cur_len_in < COLS_LEN)) begin
               ram_we     = 1'b1;
               ram_waddr  = ADDR_W'(32'(cur_phys_in) * LINE_COLUMNS) + ADDR_W'(cur_len_in);
               cur_len_in = cur_len_in + 1'b1;
            end
         end else begin
            fwd = 1'b0;
         end
      end
   end

   // response fields
   always_comb begin
      s1_rsp_in               = '0;
      s1_rsp_in.log_valid     = fwd;
      s1_rsp_in.log_byte      = fwd ? rx_b : 8'h00;
      s1_rsp_in.in_escape     = esc_in;
      s1_rsp_in.line_advanced = advanced;
      s1_rsp_in.scrolled      = scrolled;
      s1_rsp_in.cursor_row    = 3'(cur_row_in);
      s1_rsp_in.cursor_col    = 5'(cur_len_in);
      s1_rsp_in.row_length    = is_rd ? 5'(rd_len) : 5'd0;
      s1_cell_en_in           = ram_re;
      s1_valid_in             = accept || (s1_valid_ff && !s1_move);

      out_in           = s1_rsp_ff;
      out_in.cell_char = s1_cell_en_ff ? ram_rdata : 8'h00;
      out_valid_in     = s1_move || (out_valid_ff && rsp_stall);
   end

   ttlb_ram #(
      .WIDTH  (8),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (rx_b),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         cur_row_ff   <= '0;
         cur_phys_ff  <= '0;
         cur_len_ff   <= '0;
         esc_ff       <= 1'b0;
         prev_ff      <= 8'h00;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < SCREEN_LINES; i++) begin
            row_len_ff[i] <= '0;
         end
      end else begin
         top_ff       <= top_in;
         cur_row_ff   <= cur_row_in;
         cur_phys_ff  <= cur_phys_in;
         cur_len_ff   <= cur_len_in;
         esc_ff       <= esc_in;
         prev_ff      <= prev_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (row_wr_en) begin
            row_len_ff[cur_phys_in] <= cur_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff     <= s1_rsp_in;
         s1_cell_en_ff <= s1_cell_en_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      cur_len_ff <= COLS_LEN)
      else $error("current line length beyond line width");

   a_rows_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_row_ff) < SCREEN_LINES) && (32'(top_ff) < SCREEN_LINES))
      else $error("cursor or top row out of range");

   a_phys_track: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, top_ff} + {1'b0, cur_row_ff}) == {1'b0, cur_phys_ff}) ||
      (({1'b0, top_ff} + {1'b0, cur_row_ff}) ==
       ({1'b0, cur_phys_ff} + (ROW_W+1)'(SCREEN_LINES))))
      else $error("physical cursor row out of step with top and cursor row");

   a_len_shadow: assert property (@(posedge clock) disable iff (reset)
      row_len_ff[cur_phys_ff] == cur_len_ff)
      else $error("current length register disagrees with row length table");

   a_scroll_adv: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.scrolled |-> out_ff.line_advanced)
      else $error("scroll without line advance");
`endif

endmodule

### hw/rtl/ttlb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttlb_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### test/terminal_text_line_buffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_text_line_buffer_checker
// Watches both channels of the line buffer and checks every response.
// Each accepted request is run through a screen model kept here. The model
// covers the escape filter, the line packing, the scrolling and the cell
// reads. The result is queued, and each accepted response is compared with
// the oldest queued result field by field.
// ----------------------------------------------------------------------------
module terminal_text_line_buffer_checker import ttlb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      expect_depth,
   output int      mismatch_total
);

   localparam int ROWS = SCREEN_LINES_DEF;
   localparam int COLS = LINE_COLUMNS_DEF;

   // screen model, indexed by physical row
   logic [7:0]  glyph_ram [ROWS][COLS];
   logic [4:0]  line_len [ROWS];
   int unsigned top_line;
   int unsigned cursor_line;
   logic        esc_skip;
   logic [7:0]  last_byte;

   rsp_type     awaited_rsp [$];
   rsp_type     want;
   int          mismatches = 0;

   function automatic int unsigned screen_to_ram(input int unsigned screen_row);
      return (top_line + screen_row) % ROWS;
   endfunction

   function automatic logic letter_byte(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic eol_byte(input logic [7:0] b);
      return b == CH_CR || b == CH_LF;
   endfunction

   function automatic rsp_type screen_step(input req_type r);
      rsp_type     o;
      logic        wrap;
      int unsigned ph;
      int unsigned len;
      o = '0;
      if (r.operation == OP_READ) begin
         if (r.read_row < ROWS) begin
            ph = screen_to_ram(r.read_row);
            o.row_length = line_len[ph];
            if (r.read_col < line_len[ph] && r.read_col < COLS)
               o.cell_char = glyph_ram[ph][r.read_col];
         end
      end else begin
         if (esc_skip) begin
            if (letter_byte(r.rx_byte))
               esc_skip = 1'b0;
         end else if (r.rx_byte == CH_LBRACKET && last_byte == CH_ESC) begin
            esc_skip = 1'b1;
         end else if ((r.rx_byte >= CH_SPACE && r.rx_byte <= CH_TILDE) ||
                      eol_byte(r.rx_byte)) begin
            o.log_valid = 1'b1;
            o.log_byte  = r.rx_byte;
            // full line, or the first break of a run
            wrap = (line_len[screen_to_ram(cursor_line)] >= COLS) ||
                   (eol_byte(r.rx_byte) && !eol_byte(last_byte));
            if (wrap) begin
               o.line_advanced = 1'b1;
               if (cursor_line + 1 < ROWS) begin
                  cursor_line++;
               end else begin
                  o.scrolled = 1'b1;
                  top_line = (top_line + 1) % ROWS;
                  line_len[screen_to_ram(cursor_line)] = '0;
               end
            end
            if (!eol_byte(r.rx_byte)) begin
               ph  = screen_to_ram(cursor_line);
               len = line_len[ph];
               if (len < COLS) begin
                  glyph_ram[ph][len] = r.rx_byte;
                  line_len[ph] = 5'(len + 1);
               end
            end
         end
         last_byte = r.rx_byte;
      end
      o.in_escape  = esc_skip;
      o.cursor_row = 3'(cursor_line);
      o.cursor_col = line_len[screen_to_ram(cursor_line)];
      return o;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++)
            line_len[i] = '0;
         top_line    = 0;
         cursor_line = 0;
         esc_skip    = 1'b0;
         last_byte   = '0;
         awaited_rsp.delete();
      end else begin
         if (req_valid && !req_stall)
            awaited_rsp.push_back(screen_step(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("log_valid", want.log_valid, rsp_payload.log_valid);
               check_field("log_byte", want.log_byte, rsp_payload.log_byte);
               check_field("in_escape", want.in_escape, rsp_payload.in_escape);
               check_field("line_advanced", want.line_advanced,
                           rsp_payload.line_advanced);
               check_field("scrolled", want.scrolled, rsp_payload.scrolled);
               check_field("cursor_row", want.cursor_row, rsp_payload.cursor_row);
               check_field("cursor_col", want.cursor_col, rsp_payload.cursor_col);
               check_field("cell_char", want.cell_char, rsp_payload.cell_char);
               check_field("row_length", want.row_length, rsp_payload.row_length);
            end
         end
      end
      expect_depth   <= awaited_rsp.size();
      mismatch_total <= mismatches;
   end

endmodule

### test/terminal_text_line_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_text_line_buffer_tb
// Stimulus and verdict for the terminal text line buffer.
// A directed opening covers the byte classes, escape sequences, packed line
// breaks and out-of-range reads. It is followed by randomized text, break
// runs, escape sequences, cell reads and noise. Both channels idle at random,
// and the checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module terminal_text_line_buffer_tb import ttlb_pkg::*; ();

   localparam int RANDOM_ITEMS = 400;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int          expect_depth;
   int          mismatch_total;
   int          items_sent  = 0;
   int          idle_cycles = 0;
   int          next_drain  = 130;
   int unsigned sink_hold   = 0;
   int unsigned sink_next;
   logic        calm        = 1'b0;

   terminal_text_line_buffer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   terminal_text_line_buffer_checker screen_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .expect_depth   (expect_depth),
      .mismatch_total (mismatch_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: hold stall for a random count of cycles per response
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         sink_next = calm ? 0 : $urandom_range(0, 3);
         sink_hold <= sink_next;
         rsp_stall <= (sink_next != 0);
      end else if (rsp_valid && rsp_stall) begin
         sink_hold <= sink_hold - 1;
         rsp_stall <= (sink_hold > 1);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic push_request(input req_type r);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // unused fields are filled at random so every bit moves
   task automatic send_rx(input logic [7:0] b);
      req_type r;
      r           = req_type'($urandom);
      r.operation = OP_RECEIVE;
      r.rx_byte   = b;
      push_request(r);
   endtask

   task automatic send_read(input logic [2:0] row, input logic [4:0] col);
      req_type r;
      r           = req_type'($urandom);
      r.operation = OP_READ;
      r.read_row  = row;
      r.read_col  = col;
      push_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expect_depth != 0);
   endtask

   function automatic logic [7:0] any_letter();
      return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                  : 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   task automatic random_chunk();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         repeat ($urandom_range(1, 30))
            send_rx(8'($urandom_range(CH_SPACE, CH_TILDE)));
      end else if (kind < 55) begin
         repeat ($urandom_range(1, 3))
            send_rx($urandom_range(0, 1) ? CH_CR : CH_LF);
      end else if (kind < 70) begin
         send_rx(CH_ESC);
         send_rx(CH_LBRACKET);
         repeat ($urandom_range(0, 3))
            send_rx($urandom_range(0, 3) == 0 ? 8'h3B : 8'($urandom_range(8'h30, 8'h39)));
         send_rx(any_letter());
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 5) == 0)
               send_read(3'($urandom), 5'($urandom));
            else
               send_read(3'($urandom_range(0, 5)), 5'($urandom_range(0, 21)));
         end
      end else begin
         // noise and broken escapes
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 2) == 0)
               send_rx(CH_ESC);
            send_rx(8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_read(3'd0, 5'd0);
      send_rx(8'h41);
      send_rx(CH_SPACE);
      send_rx(CH_TILDE);
      send_rx(8'h00);
      send_rx(8'h7F);
      send_rx(8'hFF);
      send_rx(8'h80);
      // full escape sequence ended by a lowercase letter
      send_rx(CH_ESC);
      send_rx(CH_LBRACKET);
      send_rx(8'h33);
      send_rx(8'h3B);
      send_rx(8'h6D);
      // ESC not followed by a bracket, then a lone bracket
      send_rx(CH_ESC);
      send_rx(8'h78);
      send_rx(CH_LBRACKET);
      // a run of breaks packs into one new line
      send_rx(CH_CR);
      send_rx(CH_LF);
      send_rx(CH_LF);
      send_rx(CH_ESC);
      send_rx(CH_LBRACKET);
      send_rx(8'h5A);
      send_read(3'd0, 5'd1);
      send_read(3'd7, 5'd0);
      send_read(3'd0, 5'd31);
      send_read(3'd5, 5'd0);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         calm <= ($urandom_range(0, 5) == 0);
         random_chunk();
         if (items_sent >= next_drain) begin
            wait_drained();
            next_drain += 130;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### terminal_text_line_buffer.f
hw/rtl/ttlb_pkg.sv
hw/rtl/ttlb_ram.sv
hw/rtl/terminal_text_line_buffer.sv
test/terminal_text_line_buffer_checker.sv
test/terminal_text_line_buffer_tb.sv
